### rtl/sli_pkg.sv
// ============================================================================
// sli_pkg: shared types and constants for the sorted list core
// Holds the action and status codes, the default capacity and the control
// bundle that the core sends to every list cell.
// ============================================================================
package sli_pkg;

    // Default number of list cells.
    localparam int SLI_CAPACITY = 16;

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Action codes on the input channel.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Status codes on the output channel.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctl;

endpackage

### rtl/sli_cell.sv
// ============================================================================
// sli_cell: one position of the sorted list
// Holds one entry, compares it with the broadcast value and, on an insert or
// a remove, takes the entry of its left or right neighbor or the new value.
// ============================================================================
module sli_cell
    import sli_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int CNT_W   = 5
) (
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [CNT_W-1:0]           i_count,
    input  logic signed [VALUE_W-1:0]  i_left_val,
    input  logic                       i_left_below,
    input  logic signed [VALUE_W-1:0]  i_right_val,
    output logic signed [VALUE_W-1:0]  o_val,
    output logic                       o_below,
    output logic                       o_hit
);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;
    logic                      held;

    // The entry is live when its position is below the entry count.
    assign held    = (i_count > CNT_W'(IDX));
    assign o_below = held && (r_val < i_value);
    // The first entry not below the value is the first equal one, if any.
    assign o_hit   = held && (r_val == i_value) && i_left_below;
    assign o_val   = r_val;

    // Entries below the value stay; the rest shift toward the gap.
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins_en && !o_below) begin
            n_val = i_left_below ? i_value : i_left_val;
        end else if (i_ctl.rem_en && !o_below) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### rtl/sorted_list_insert_remove_core.sv
// ============================================================================
// sorted_list_insert_remove_core: ascending list of signed values
// Inserts before the first entry not smaller, removes the first equal entry
// and reads an entry by position, using a row of cells that shift in place.
// ============================================================================
//
//  Channel   Signals                                    Direction
//  --------  -----------------------------------------  ---------
//  input     i_valid, o_ready, i_action, i_value,       in
//            i_index
//  output    o_valid, i_ready, o_status, o_entry_count, out
//            o_read_value
//
// All cells compare the value and shift together for every item,
// so one item is accepted per cycle while the output register can take it.
// The result appears in the output register the cycle after acceptance.
// Reset clears the entry count and the output valid; cell contents need none.
// A stalled result holds the output register and the input waits with it.
//
module sorted_list_insert_remove_core
    import sli_pkg::*;
#(
    parameter int CAPACITY = SLI_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_action,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [INDEX_W-1:0]         i_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [COUNT_W-1:0]         o_entry_count,
    output logic signed [VALUE_W-1:0]  o_read_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RD_N  = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    t_status                   r_status;
    t_status                   n_status;
    logic [COUNT_W-1:0]        r_out_count;
    logic signed [VALUE_W-1:0] r_rd;
    logic signed [VALUE_W-1:0] n_rd;

    logic signed [VALUE_W-1:0] cell_val   [CAPACITY];
    logic [CAPACITY-1:0]       cell_below;
    logic [CAPACITY-1:0]       cell_hit;
    t_cell_ctl                 ctl;
    t_action                   act;
    logic                      accept;
    logic                      full;
    logic                      found;
    logic                      idx_ok;
    logic [CNT_W+INDEX_W-1:0]  idx_ext;
    logic [CNT_W+INDEX_W-1:0]  cnt_ext;
    logic [CNT_W+COUNT_W-1:0]  out_cnt_ext;

    // Handshake: accept whenever the output register is free or draining.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign act     = t_action'(i_action);

    // List conditions.
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign found   = |cell_hit;
    assign idx_ext = {{CNT_W{1'b0}}, i_index};
    assign cnt_ext = {{INDEX_W{1'b0}}, r_count};
    assign idx_ok  = (idx_ext < cnt_ext) && (idx_ext < (CNT_W + INDEX_W)'(CAPACITY));

    // Command to the cells.
    always_comb begin
        ctl.ins_en = accept && (act == ACT_INSERT) && !full;
        ctl.rem_en = accept && (act == ACT_REMOVE) && found;
    end

    // Row of cells; each sees its neighbors' entries.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [VALUE_W-1:0] left_val;
        logic                      left_below;
        logic signed [VALUE_W-1:0] right_val;

        if (k == 0) begin : g_first
            assign left_val   = i_value;
            assign left_below = 1'b1;
        end else begin : g_mid
            assign left_val   = cell_val[k-1];
            assign left_below = cell_below[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[k];
        end else begin : g_body
            assign right_val = cell_val[k+1];
        end

        sli_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_value      (i_value),
            .i_count      (r_count),
            .i_left_val   (left_val),
            .i_left_below (left_below),
            .i_right_val  (right_val),
            .o_val        (cell_val[k]),
            .o_below      (cell_below[k]),
            .o_hit        (cell_hit[k])
        );
    end

    // Result of the current item and the next entry count.
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = '0;
        case (act)
            ACT_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            ACT_READ: begin
                if (idx_ok) begin
                    for (int k = 0; k < RD_N; k++) begin
                        if (i_index == INDEX_W'(k)) begin
                            n_rd = cell_val[k];
                        end
                    end
                end else begin
                    n_status = ST_BAD_INDEX;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign out_cnt_ext = {{COUNT_W{1'b0}}, n_count};

    // Entry count and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_count <= out_cnt_ext[COUNT_W-1:0];
            r_rd        <= n_rd;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;
    assign o_read_value  = r_rd;

endmodule

### tb/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for the sorted list core
// Drives insert, remove and read items through the valid/ready input channel
// and checks every result against a shadow copy of the list that is updated
// as items are accepted. A short directed table comes first, then randomized
// phases fill, drain and churn the list; both sides idle at random until calm.
// ============================================================================
module tb_top;
    import sli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS  = 1850;
    localparam int CALM_ITEMS  = 250;
    localparam int PHASE_ITEMS = 150;

    // One expected result item.
    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   rd;
    } t_list_answer;

    // One row of the directed table; known rows carry their answer.
    typedef struct packed {
        t_action              act;
        logic [VALUE_W-1:0]   val;
        logic [INDEX_W-1:0]   idx;
        logic                 known;
        t_list_answer         ans;
    } t_dir_row;

    // Clock and block ports; the driven ones are known from time zero.
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_action      = ACT_NONE;
    logic signed [VALUE_W-1:0] i_value       = '0;
    logic [INDEX_W-1:0]        i_index       = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b1;
    logic [1:0]                o_status;
    logic [COUNT_W-1:0]        o_entry_count;
    logic signed [VALUE_W-1:0] o_read_value;

    // Shadow list state and the answers still to come.
    logic signed [VALUE_W-1:0] shadow_list [SLI_CAPACITY];
    int                        shadow_count = 0;
    t_list_answer              answers_due [$];
    t_dir_row                  dir_rows [$];
    int                        mismatch_count = 0;
    bit                        calm = 1'b0;

    sorted_list_insert_remove_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_read_value  (o_read_value)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one item to the shadow list and return the answer it gives.
    function automatic t_list_answer apply_list_op(t_action act,
                                                   logic signed [VALUE_W-1:0] val,
                                                   logic [INDEX_W-1:0] idx);
        t_list_answer ans;
        int           pos;
        int           k;
        ans.status = ST_OK;
        ans.rd     = '0;
        pos        = 0;
        case (act)
            ACT_INSERT: begin
                if (shadow_count >= SLI_CAPACITY) begin
                    ans.status = ST_FULL;
                end else begin
                    // Equal entries stay above the new one.
                    while (pos < shadow_count && shadow_list[pos] < val) pos++;
                    for (k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                end
            end
            ACT_REMOVE: begin
                // The lowest-placed equal entry goes.
                while (pos < shadow_count && shadow_list[pos] != val) pos++;
                if (pos >= shadow_count) begin
                    ans.status = ST_NOT_FOUND;
                end else begin
                    for (k = pos; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
                    shadow_count--;
                end
            end
            ACT_READ: begin
                if (int'(idx) < shadow_count) ans.rd = shadow_list[idx];
                else ans.status = ST_BAD_INDEX;
            end
            default: begin
            end
        endcase
        ans.count = COUNT_W'(shadow_count);
        return ans;
    endfunction

    // Present one item, wait for acceptance, record its answer, then maybe idle.
    task automatic send_item(t_action act, logic signed [VALUE_W-1:0] val,
                             logic [INDEX_W-1:0] idx, logic known, t_list_answer fixed_ans);
        t_list_answer ans;
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        i_index  <= idx;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        ans = apply_list_op(act, val, idx);
        answers_due.push_back(known ? fixed_ans : ans);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Result side: random stall bursts, none once the run turns calm.
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Compare each accepted result item with the oldest answer due.
    always @(posedge i_clk) begin
        t_list_answer want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (answers_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with no answer due: st=%0d cnt=%0d rd=%h",
                             $realtime, o_status, o_entry_count, o_read_value);
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status || o_entry_count !== want.count ||
                    o_read_value !== want.rd) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp st=%0d cnt=%0d rd=%h got st=%0d cnt=%0d rd=%h",
                                 $realtime, want.status, want.count, want.rd,
                                 o_status, o_entry_count, o_read_value);
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        t_dir_row                  row;
        t_action                   act;
        logic signed [VALUE_W-1:0] val;
        logic [INDEX_W-1:0]        idx;
        int                        roll;
        int                        mode;
        int                        ins_cut;
        int                        rem_cut;
        int                        waited;

        // Empty list, unused action and the two extreme values.
        dir_rows.push_back('{ACT_READ,   32'd0,         4'd0,  1'b1, '{ST_BAD_INDEX, 5'd0, 32'd0}});
        dir_rows.push_back('{ACT_REMOVE, 32'h8000_0000, 4'd0,  1'b1, '{ST_NOT_FOUND, 5'd0, 32'd0}});
        dir_rows.push_back('{ACT_NONE,   32'h7FFF_FFFF, 4'd15, 1'b1, '{ST_OK, 5'd0, 32'd0}});
        dir_rows.push_back('{ACT_INSERT, 32'h7FFF_FFFF, 4'd15, 1'b1, '{ST_OK, 5'd1, 32'd0}});
        dir_rows.push_back('{ACT_INSERT, 32'h8000_0000, 4'd0,  1'b1, '{ST_OK, 5'd2, 32'd0}});
        dir_rows.push_back('{ACT_READ,   32'd0,         4'd0,  1'b1,
                             '{ST_OK, 5'd2, 32'h8000_0000}});
        dir_rows.push_back('{ACT_READ,   32'd0,         4'd2,  1'b1, '{ST_BAD_INDEX, 5'd2, 32'd0}});
        // Equal values, then a remove of one of them and a remove that misses.
        dir_rows.push_back('{ACT_INSERT, 32'd0,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd0,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_REMOVE, 32'd0,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_REMOVE, 32'd12345,     4'd0,  1'b0, '0});
        // Fill the list to capacity.
        dir_rows.push_back('{ACT_INSERT, 32'hFFFF_FFFF, 4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd1,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd100,       4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'hFFFF_FF9C, 4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd7,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd7,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'h1234_5678, 4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'hEDCB_A988, 4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd3,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'hFFFF_FFFB, 4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'd2,         4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'h4000_0000, 4'd0,  1'b0, '0});
        dir_rows.push_back('{ACT_INSERT, 32'hBFFF_FFFF, 4'd0,  1'b0, '0});
        // Full list refuses, the top entry reads back, then leaves.
        dir_rows.push_back('{ACT_INSERT, 32'd9,         4'd0,  1'b1, '{ST_FULL, 5'd16, 32'd0}});
        dir_rows.push_back('{ACT_READ,   32'd0,         4'd15, 1'b1,
                             '{ST_OK, 5'd16, 32'h7FFF_FFFF}});
        dir_rows.push_back('{ACT_REMOVE, 32'h7FFF_FFFF, 4'd0,  1'b0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            send_item(row.act, row.val, row.idx, row.known, row.ans);
        end

        // Random phases rotate between filling, draining and churning.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= RAND_ITEMS - CALM_ITEMS);
            mode = (n / PHASE_ITEMS) % 3;
            case (mode)
                0:       begin ins_cut = 60; rem_cut = 80; end
                1:       begin ins_cut = 20; rem_cut = 75; end
                default: begin ins_cut = 38; rem_cut = 72; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_cut)      act = ACT_INSERT;
            else if (roll < rem_cut) act = ACT_REMOVE;
            else if (roll < 96)      act = ACT_READ;
            else                     act = ACT_NONE;

            idx  = INDEX_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (act == ACT_REMOVE && shadow_count > 0 && roll < 60) begin
                // Mostly take a value that is in the list so removes hit.
                val = shadow_list[$urandom_range(0, shadow_count - 1)];
            end else if (roll < 50) begin
                // A narrow pool around zero makes duplicates common.
                val = int'($urandom_range(0, 15)) - 8;
            end else if (act == ACT_INSERT && roll < 65) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = 32'd0;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end else begin
                val = $urandom;
            end
            send_item(act, val, idx, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // Let the remaining results drain, then a few quiet cycles.
        waited = 0;
        while (answers_due.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (answers_due.size() != 0) begin
            mismatch_count += answers_due.size();
            $display("%0t: %0d result items never arrived", $realtime, answers_due.size());
        end
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
